// ----- rtl/bcsd_pkg.sv -----
// ----------------------------------------------------------------------------
// BMS CAN frame status decoder package
// Shared types and constants: frame ids, register indexes, payload structs.
// ----------------------------------------------------------------------------
package bcsd_pkg;

  // Frame identifiers
  localparam logic [10:0] ID_LIMITS  = 11'h351;
  localparam logic [10:0] ID_SOC_SOH = 11'h355;
  localparam logic [10:0] ID_TELEM   = 11'h356;
  localparam logic [10:0] ID_FLAGS   = 11'h359;
  localparam logic [10:0] ID_REQUEST = 11'h35C;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_CAPACITY = 2'd0,
    REG_MAX_VOLT = 2'd1,
    REG_MIN_VOLT = 2'd2
  } cfg_reg_e;

  localparam logic [19:0] CAPACITY_RST = 20'd30000;
  localparam logic [15:0] MAX_VOLT_RST = 16'd584;
  localparam logic [15:0] MIN_VOLT_RST = 16'd400;

  localparam logic [6:0]  PCT_MAX          = 7'd100;
  localparam logic [21:0] FORCE_CHARGE_W   = 22'd500;
  localparam logic [7:0]  FORCE_REQ_MASK   = 8'h0C;
  localparam logic [5:0]  CHG_PROTECT_MASK = 6'h15;
  localparam logic [5:0]  DIS_PROTECT_MASK = 6'h2A;

  typedef struct packed {
    logic [10:0] can_id;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
    logic [7:0]  byte4;
    logic [7:0]  byte5;
    logic [7:0]  byte6;
    logic [7:0]  byte7;
  } in_t;

  typedef struct packed {
    logic        [13:0] soc_pptt;
    logic        [13:0] health_pptt;
    logic        [19:0] remaining_energy_wh;
    logic        [12:0] pack_voltage_dv;
    logic signed [15:0] pack_current_da;
    logic        [21:0] charge_power_w;
    logic        [21:0] discharge_power_w;
    logic        [15:0] max_voltage_dv;
    logic        [15:0] min_voltage_dv;
    logic signed [15:0] temperature_dc;
    logic               fault_flag;
    logic        [5:0]  alarm_flags;
  } out_t;

  typedef struct packed {
    logic [19:0] capacity_wh;
    logic [15:0] max_volt_dv;
    logic [15:0] min_volt_dv;
  } cfg_t;

  // Decoded battery state held between frames
  typedef struct packed {
    logic [15:0] charge_curr_limit;
    logic [15:0] discharge_curr_limit;
    logic [15:0] last_pos_max_volt;
    logic [15:0] last_pos_min_volt;
    logic [6:0]  soc_pct;
    logic [6:0]  soh_pct;
    logic [12:0] pack_volt;
    logic [15:0] pack_curr;
    logic [15:0] pack_temp;
    logic [5:0]  protect_bits;
    logic [5:0]  warning_bits;
    logic        any_fault;
    logic        force_charge;
  } state_t;

  // Product stage contents
  typedef struct packed {
    out_t        base;
    logic [26:0] energy_prod;
    logic [27:0] chg_prod;
    logic [27:0] dis_prod;
    logic        chg_kill;
    logic        dis_kill;
    logic        force_min;
  } prod_t;

endpackage

// ----- rtl/bcsd_state.sv -----
// ----------------------------------------------------------------------------
// BMS CAN frame state stage
// Decodes one frame and updates the stored battery state on acceptance.
// ----------------------------------------------------------------------------
module bcsd_state (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bcsd_pkg::in_t   in_data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output bcsd_pkg::state_t state_o
);
  import bcsd_pkg::*;

  logic        valid_q;
  state_t      state_q, state_d;
  logic [15:0] w01, w23, w45, w67;
  logic [32:0] volt_prod;

  // Map a raw flag byte to alarm bit order
  function automatic logic [5:0] remap_flags(input logic [7:0] f);
    logic [5:0] r;
    r[0] = f[4];
    r[1] = f[3];
    r[2] = f[6];
    r[3] = f[5];
    r[4] = f[2];
    r[5] = f[1];
    return r;
  endfunction

  function automatic logic [6:0] sat100(input logic [15:0] v);
    return (v > 16'(PCT_MAX)) ? PCT_MAX : v[6:0];
  endfunction

  assign w01 = {in_data_i.byte1, in_data_i.byte0};
  assign w23 = {in_data_i.byte3, in_data_i.byte2};
  assign w45 = {in_data_i.byte5, in_data_i.byte4};
  assign w67 = {in_data_i.byte7, in_data_i.byte6};

  // Divide by ten: multiply by ceil(2^19 / 10), exact for 16-bit values
  assign volt_prod = 33'(w01) * 33'd52429;

  assign in_ready_o = !valid_q || ready_i;
  assign valid_o    = valid_q;
  assign state_o    = state_q;

  always_comb begin
    state_d = state_q;
    case (in_data_i.can_id)
      ID_LIMITS: begin
        state_d.charge_curr_limit    = w23;
        state_d.discharge_curr_limit = w45;
        if (w01 != 16'd0) begin
          state_d.last_pos_max_volt = w01;
        end
        if (w67 != 16'd0) begin
          state_d.last_pos_min_volt = w67;
        end
      end
      ID_SOC_SOH: begin
        state_d.soc_pct = sat100(w01);
        state_d.soh_pct = sat100(w23);
      end
      ID_TELEM: begin
        state_d.pack_volt = volt_prod[31:19];
        state_d.pack_curr = w23;
        state_d.pack_temp = w45;
      end
      ID_FLAGS: begin
        state_d.protect_bits = remap_flags(in_data_i.byte0);
        state_d.warning_bits = remap_flags(in_data_i.byte2);
        state_d.any_fault    = (in_data_i.byte0 != 8'd0) || (in_data_i.byte1 != 8'd0);
      end
      ID_REQUEST: begin
        state_d.force_charge = (in_data_i.byte4 & FORCE_REQ_MASK) != 8'd0;
      end
      default: begin
        state_d = state_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      state_q <= '0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
      if (in_valid_i) begin
        state_q <= state_d;
      end
    end
  end

endmodule

// ----- rtl/bcsd_mult.sv -----
// ----------------------------------------------------------------------------
// BMS CAN frame product stage
// Forms the energy and power products and the simple status fields.
// ----------------------------------------------------------------------------
module bcsd_mult (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  bcsd_pkg::state_t state_i,
  input  bcsd_pkg::cfg_t   cfg_i,
  output logic             valid_o,
  input  logic             ready_i,
  output bcsd_pkg::prod_t  prod_o
);
  import bcsd_pkg::*;

  logic        valid_q;
  prod_t       prod_q, prod_d;
  logic [14:0] chg_curr, dis_curr;

  // Negative current limits give no power
  assign chg_curr = state_i.charge_curr_limit[15]    ? 15'd0 : state_i.charge_curr_limit[14:0];
  assign dis_curr = state_i.discharge_curr_limit[15] ? 15'd0 : state_i.discharge_curr_limit[14:0];

  always_comb begin
    prod_d.energy_prod = 27'(state_i.soc_pct) * 27'(cfg_i.capacity_wh);
    prod_d.chg_prod    = 28'(chg_curr) * 28'(state_i.pack_volt);
    prod_d.dis_prod    = 28'(dis_curr) * 28'(state_i.pack_volt);
    prod_d.chg_kill    = (state_i.protect_bits & CHG_PROTECT_MASK) != 6'd0;
    prod_d.dis_kill    = (state_i.protect_bits & DIS_PROTECT_MASK) != 6'd0;
    // Force charge sets a minimum power when blocked or below one watt
    prod_d.force_min   = state_i.force_charge && (state_i.pack_volt != 13'd0) &&
                         (prod_d.chg_kill || (prod_d.chg_prod < 28'd100));

    prod_d.base.soc_pptt            = 14'(state_i.soc_pct) * 14'd100;
    prod_d.base.health_pptt         = 14'(state_i.soh_pct) * 14'd100;
    prod_d.base.remaining_energy_wh = '0;
    prod_d.base.pack_voltage_dv     = state_i.pack_volt;
    prod_d.base.pack_current_da     = $signed(state_i.pack_curr);
    prod_d.base.charge_power_w      = '0;
    prod_d.base.discharge_power_w   = '0;
    prod_d.base.max_voltage_dv      = (state_i.last_pos_max_volt != 16'd0) ?
                                      state_i.last_pos_max_volt : cfg_i.max_volt_dv;
    prod_d.base.min_voltage_dv      = (state_i.last_pos_min_volt != 16'd0) ?
                                      state_i.last_pos_min_volt : cfg_i.min_volt_dv;
    prod_d.base.temperature_dc      = $signed(state_i.pack_temp);
    prod_d.base.fault_flag          = state_i.any_fault;
    prod_d.base.alarm_flags         = state_i.protect_bits | state_i.warning_bits;
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign prod_o  = prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      prod_q <= prod_d;
    end
  end

endmodule

// ----- rtl/bcsd_result.sv -----
// ----------------------------------------------------------------------------
// BMS CAN frame result stage
// Scales the products down by one hundred and applies protection rules.
// ----------------------------------------------------------------------------
module bcsd_result (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  bcsd_pkg::prod_t prod_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bcsd_pkg::out_t  out_data_o
);
  import bcsd_pkg::*;

  // ceil(2^34 / 100): exact floor division for operands below 2^28
  localparam logic [27:0] DIV100_MUL = 28'd171798692;

  logic        valid_q;
  out_t        out_q, out_d;
  logic [21:0] energy_q100, chg_q100, dis_q100;

  function automatic logic [21:0] div100(input logic [27:0] x);
    logic [55:0] p;
    p = 56'(x) * 56'(DIV100_MUL);
    return p[55:34];
  endfunction

  assign energy_q100 = div100(28'(prod_i.energy_prod));
  assign chg_q100    = div100(prod_i.chg_prod);
  assign dis_q100    = div100(prod_i.dis_prod);

  always_comb begin
    out_d                     = prod_i.base;
    out_d.remaining_energy_wh = energy_q100[19:0];
    if (prod_i.force_min) begin
      out_d.charge_power_w = FORCE_CHARGE_W;
    end else if (prod_i.chg_kill) begin
      out_d.charge_power_w = '0;
    end else begin
      out_d.charge_power_w = chg_q100;
    end
    out_d.discharge_power_w = prod_i.dis_kill ? 22'd0 : dis_q100;
  end

  assign ready_o     = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      out_q <= out_d;
    end
  end

endmodule

// ----- rtl/bms_can_frame_status_decoder_top.sv -----
// ----------------------------------------------------------------------------
// BMS CAN frame status decoder
// Decodes battery management CAN frames into one status word per frame.
// ----------------------------------------------------------------------------
// Each accepted word is one received CAN frame (11-bit id, eight data bytes).
// Frames 0x351 (voltage/current limits), 0x355 (SOC/SOH), 0x356 (voltage,
// current, temperature), 0x359 (protection, fault, warning flags) and 0x35C
// (force-charge request) update the stored battery state; any other id leaves
// it alone. Every frame produces exactly one status word, in order, computed
// from the state after that frame. The block is a three-stage pipeline: the
// state register (frame decode), a product register (energy and power
// products) and the output register (divide by 100 through a reciprocal
// multiply, protection and force-charge rules). One frame can be accepted in
// every cycle; each stage holds while the stage after it is full and stalled.
// Configuration registers (capacity, default max/min voltage) are to be
// written through cfg_we_i/cfg_idx_i/cfg_wdata_i only while no frame is in
// flight; the block itself does not enforce this. An index beyond the
// register list is dropped.
// ----------------------------------------------------------------------------
module bms_can_frame_status_decoder_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  // Configuration write port
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [19:0]    cfg_wdata_i,
  // Frame input
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bcsd_pkg::in_t  in_data_i,
  // Status output
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bcsd_pkg::out_t out_data_o
);
  import bcsd_pkg::*;

  cfg_t    cfg_q;
  logic    st_valid, prod_ready;
  state_t  st_state;
  logic    prod_valid, res_ready;
  prod_t   prod;

  // Configuration registers: mask each write to the register width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capacity_wh <= CAPACITY_RST;
      cfg_q.max_volt_dv <= MAX_VOLT_RST;
      cfg_q.min_volt_dv <= MIN_VOLT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CAPACITY: cfg_q.capacity_wh <= cfg_wdata_i;
        REG_MAX_VOLT: cfg_q.max_volt_dv <= cfg_wdata_i[15:0];
        REG_MIN_VOLT: cfg_q.min_volt_dv <= cfg_wdata_i[15:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  // Stage 1: decode the frame into the held battery state
  bcsd_state u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .valid_o    (st_valid),
    .ready_i    (prod_ready),
    .state_o    (st_state)
  );

  // Stage 2: energy and power products, pass-through status fields
  bcsd_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (st_valid),
    .ready_o (prod_ready),
    .state_i (st_state),
    .cfg_i   (cfg_q),
    .valid_o (prod_valid),
    .ready_i (res_ready),
    .prod_o  (prod)
  );

  // Stage 3: scale, apply protections, hold the status word
  bcsd_result u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (prod_valid),
    .ready_o     (res_ready),
    .prod_i      (prod),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
